FILE: hdl/vdp_pkg.sv
package vdp_pkg;

   // kinds of item on the request channel
   localparam logic [1:0] ACT_PORT_WRITE = 2'd0;
   localparam logic [1:0] ACT_PORT_READ  = 2'd1;
   localparam logic [1:0] ACT_KEY_PUSH   = 2'd2;
   localparam logic [1:0] ACT_RETRACE    = 2'd3;

   localparam logic [15:0] PORT_ATTR = 16'h03C0;
   localparam logic [15:0] PORT_RIDX = 16'h03C7;
   localparam logic [15:0] PORT_WIDX = 16'h03C8;
   localparam logic [15:0] PORT_DATA = 16'h03C9;
   localparam logic [15:0] PORT_STAT = 16'h03DA;
   localparam logic [15:0] PORT_KBD  = 16'h0060;

   // rgb phase codes
   localparam logic [1:0] PHASE_RED   = 2'd0;
   localparam logic [1:0] PHASE_GREEN = 2'd1;
   localparam logic [1:0] PHASE_BLUE  = 2'd2;

   localparam logic [7:0] STAT_RETRACE = 8'h08;

   localparam int KEY_QUEUE_DEPTH_DEF = 256;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic [7:0] data;
   } kq_cmd_type;

   // 6-bit dac value to 8 bits: min(255, floor(d*256/63)) = 4d + floor(4d/63)
   function automatic logic [7:0] pal_scale_up(input logic [5:0] d);
      logic [7:0] q4;
      logic [2:0] frac;
      logic [8:0] sum;
      q4   = {d, 2'b00};
      frac = 3'(q4 >= 8'd63) + 3'(q4 >= 8'd126) + 3'(q4 >= 8'd189) + 3'(q4 >= 8'd252);
      sum  = {1'b0, q4} + {6'd0, frac};
      return sum[8] ? 8'hFF : sum[7:0];
   endfunction

   // 8 bits back to 6: min(63, floor(c*64/255)) works out to c >> 2
   function automatic logic [7:0] pal_scale_down(input logic [7:0] c);
      return {2'b00, c[7:2]};
   endfunction

endpackage

FILE: hdl/vdp_key_queue.sv
module vdp_key_queue #(
   parameter int DEPTH = vdp_pkg::KEY_QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  vdp_pkg::kq_cmd_type cmd,
   output logic [7:0]          pop_data
);
   import vdp_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = PTR_W + 1;

   logic [7:0]       mem [DEPTH];
   logic [7:0]       rd_ff;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             any_ff, any_in;
   logic [SUM_W-1:0] tail_sum;
   logic [PTR_W-1:0] tail;
   logic [PTR_W-1:0] head_next;
   logic             full;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail      = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                  : tail_sum[PTR_W-1:0];
   assign head_next = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      any_in   = any_ff;
      if (cmd.push && !full) begin
         count_in = count_ff + CNT_W'(1);
         any_in   = 1'b1;
      end else if (cmd.pop && count_ff != '0) begin
         // the last pop keeps head on the entry just read
         if (count_ff > CNT_W'(1)) begin
            head_in = head_next;
         end
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         any_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         any_ff   <= any_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push && !full) begin
         mem[tail] <= cmd.data;
      end
      rd_ff <= mem[head_ff];
   end

   // before the first push pop_data reads zero, since the memory is not reset
   assign pop_data = any_ff ? rd_ff : 8'd0;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("key queue count beyond depth");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && cmd.pop))
      else $error("push and pop in one cycle");

   a_last_pop: assert property (@(posedge clock) disable iff (reset)
      cmd.pop && count_ff == CNT_W'(1) |=> count_ff == '0 && $stable(head_ff))
      else $error("last pop moved head");

   a_empty_unused: assert property (@(posedge clock) disable iff (reset)
      !any_ff |-> count_ff == '0)
      else $error("entries without any push");

endmodule

FILE: hdl/vga_dac_port_device_core.sv
// result: valid once its item has passed the execute state and the output is free
// items are taken one at a time; the registered read of the palette and key memories
// takes the accept cycle, the read-modify-write of the state the execute state after it
// reset: synchronous, active high; clears indices, phases, blink, retrace and queue pointers
// the palette memory is not cleared and the key queue needs no clearing pass
module vga_dac_port_device_core #(
   parameter int KEY_QUEUE_DEPTH = vdp_pkg::KEY_QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // port[15:0], data[23:16], retrace_active[24],
                                    // palette_present[25], zero[31:26]
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // read_data[7:0]
   output logic [1:0]  rsp_tuser    // unsupported[0], blink_on[1]
);
   import vdp_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic        state_ff, state_in;
   logic        req_acc, done;

   // item held during execution
   logic [1:0]  act_ff;
   logic [15:0] port_ff;
   logic [7:0]  data_ff;
   logic        active_ff;
   logic        pal_ok_ff;

   logic [7:0]  write_index_ff, write_index_in;
   logic [1:0]  write_phase_ff, write_phase_in;
   logic [7:0]  read_index_ff, read_index_in;
   logic [1:0]  read_phase_ff, read_phase_in;
   logic        blink_ff, blink_in;
   logic        pending_ff, pending_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, read_data;
   logic        rsp_unsup_ff, unsup;

   logic [23:0] pal_mem [256];
   logic [23:0] pal_rd_ff;
   logic [7:0]  pal_chan;
   logic [7:0]  pal_wval;
   logic        pal_we;

   kq_cmd_type  kq_cmd;
   logic [7:0]  kq_data;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign done       = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      case (read_phase_ff)
         PHASE_RED:   pal_chan = pal_rd_ff[23:16];
         PHASE_GREEN: pal_chan = pal_rd_ff[15:8];
         default:     pal_chan = pal_rd_ff[7:0];
      endcase
   end

   assign pal_wval = pal_scale_up(data_ff[5:0]);

   always_comb begin
      write_index_in = write_index_ff;
      write_phase_in = write_phase_ff;
      read_index_in  = read_index_ff;
      read_phase_in  = read_phase_ff;
      blink_in       = blink_ff;
      pending_in     = pending_ff;
      read_data      = 8'd0;
      unsup          = 1'b0;
      pal_we         = 1'b0;
      kq_cmd         = '{push: 1'b0, pop: 1'b0, data: data_ff};
      case (act_ff)
         ACT_PORT_WRITE: begin
            if (port_ff == PORT_ATTR) begin
               blink_in = data_ff[3];
            end else if (port_ff == PORT_RIDX) begin
               read_index_in = data_ff;
               read_phase_in = PHASE_RED;
            end else if (port_ff == PORT_WIDX) begin
               write_index_in = data_ff;
               write_phase_in = PHASE_RED;
            end else if (port_ff == PORT_DATA) begin
               pal_we = pal_ok_ff;
               if (write_phase_ff == PHASE_BLUE) begin
                  write_phase_in = PHASE_RED;
                  write_index_in = write_index_ff + 8'd1;
               end else begin
                  write_phase_in = write_phase_ff + 2'd1;
               end
            end else begin
               unsup = 1'b1;
            end
         end
         ACT_PORT_READ: begin
            if (port_ff == PORT_DATA) begin
               // without a palette the read gives zero and the pointer stays
               if (pal_ok_ff) begin
                  read_data = pal_scale_down(pal_chan);
                  if (read_phase_ff == PHASE_BLUE) begin
                     read_phase_in = PHASE_RED;
                     read_index_in = read_index_ff + 8'd1;
                  end else begin
                     read_phase_in = read_phase_ff + 2'd1;
                  end
               end
            end else if (port_ff == PORT_STAT) begin
               if (pending_ff || active_ff) begin
                  read_data  = STAT_RETRACE;
                  pending_in = 1'b0;
               end
            end else if (port_ff == PORT_KBD) begin
               read_data  = kq_data;
               kq_cmd.pop = done;
            end else begin
               unsup = 1'b1;
            end
         end
         ACT_KEY_PUSH: begin
            kq_cmd.push = done;
         end
         default: begin
            pending_in = 1'b1;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_acc) begin
         state_in = ST_EXEC;
      end else if (done) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         write_index_ff <= '0;
         write_phase_ff <= PHASE_RED;
         read_index_ff  <= '0;
         read_phase_ff  <= PHASE_RED;
         blink_ff       <= 1'b0;
         pending_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (done) begin
            write_index_ff <= write_index_in;
            write_phase_ff <= write_phase_in;
            read_index_ff  <= read_index_in;
            read_phase_ff  <= read_phase_in;
            blink_ff       <= blink_in;
            pending_ff     <= pending_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         act_ff    <= req_tuser;
         port_ff   <= req_tdata[15:0];
         data_ff   <= req_tdata[23:16];
         active_ff <= req_tdata[24];
         pal_ok_ff <= req_tdata[25];
      end
      if (done) begin
         rsp_data_ff  <= read_data;
         rsp_unsup_ff <= unsup;
      end
   end

   // palette: lane write at the write pointer, registered read at the read pointer
   always_ff @(posedge clock) begin
      if (done && pal_we) begin
         case (write_phase_ff)
            PHASE_RED:   pal_mem[write_index_ff][23:16] <= pal_wval;
            PHASE_GREEN: pal_mem[write_index_ff][15:8]  <= pal_wval;
            default:     pal_mem[write_index_ff][7:0]   <= pal_wval;
         endcase
      end
      pal_rd_ff <= pal_mem[read_index_ff];
   end

   vdp_key_queue #(
      .DEPTH (KEY_QUEUE_DEPTH)
   ) u_key_queue (
      .clock    (clock),
      .reset    (reset),
      .cmd      (kq_cmd),
      .pop_data (kq_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {blink_ff, rsp_unsup_ff};

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == ST_EXEC)
      else $error("accepted item not executed");

   a_done_result: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("executed item gave no result");

   a_wphase: assert property (@(posedge clock) disable iff (reset)
      write_phase_ff != 2'd3)
      else $error("write phase out of range");

   a_rphase: assert property (@(posedge clock) disable iff (reset)
      read_phase_ff != 2'd3)
      else $error("read phase out of range");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
   import vdp_pkg::*;

   localparam int KQ_DEPTH    = KEY_QUEUE_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int N_RANDOM    = 120;

   typedef struct packed {
      logic [7:0] read_data;
      logic       unsupported;
      logic       blink_on;
   } port_reply_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // port[15:0], data[23:16], retrace_active[24],
                                  // palette_present[25], zero[31:26]
   logic [1:0]  req_tuser = '0;   // action[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // read_data[7:0]
   logic [1:0]  rsp_tuser;        // unsupported[0], blink_on[1]

   vga_dac_port_device_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // two copies of the device state: [0] follows the items as they are generated,
   // [1] follows the items as the device accepts them
   logic [23:0] pal_mem  [2][256];
   logic [2:0]  pal_seen [2][256];   // channels written so far, one bit per phase
   logic [7:0]  key_mem  [2][KQ_DEPTH];
   logic [7:0]  wr_idx   [2];
   logic [1:0]  wr_ph    [2];
   logic [7:0]  rd_idx   [2];
   logic [1:0]  rd_ph    [2];
   logic        blink_st [2];
   logic        retr_pend[2];
   int          key_head [2];
   int          key_cnt  [2];

   logic [33:0] pending[$];          // {action, tdata}
   port_reply_t replies_due[$];

   int  n_queued    = 0;
   int  n_accepted  = 0;
   int  n_checked   = 0;
   int  n_errors    = 0;
   int  n_pal_reads = 0;
   int  n_unsup     = 0;
   int  cycle_count = 0;
   bit  queue_filled = 0;
   bit  req_took = 0;
   bit  req_calm = 0;
   bit  rsp_calm = 0;
   int  req_hold = 0;
   int  rsp_hold = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   function automatic void dac_state_clear(input int cp);
      for (int i = 0; i < 256; i++) begin
         pal_mem[cp][i]  = '0;
         pal_seen[cp][i] = '0;
      end
      for (int i = 0; i < KQ_DEPTH; i++) key_mem[cp][i] = '0;
      wr_idx[cp]    = '0;
      wr_ph[cp]     = PHASE_RED;
      rd_idx[cp]    = '0;
      rd_ph[cp]     = PHASE_RED;
      blink_st[cp]  = 1'b0;
      retr_pend[cp] = 1'b0;
      key_head[cp]  = 0;
      key_cnt[cp]   = 0;
   endfunction

   // advances one copy of the state by one item and gives the reply it causes
   function automatic void dac_port_step(input int cp, input logic [1:0] act,
      input logic [15:0] port, input logic [7:0] din, input logic active,
      input logic pal_ok, output port_reply_t rep);
      int unsigned d6, level, sh;
      rep = '0;
      case (act)
         ACT_PORT_WRITE: begin
            if (port == PORT_ATTR) begin
               blink_st[cp] = din[3];
            end else if (port == PORT_RIDX) begin
               rd_idx[cp] = din;
               rd_ph[cp]  = PHASE_RED;
            end else if (port == PORT_WIDX) begin
               wr_idx[cp] = din;
               wr_ph[cp]  = PHASE_RED;
            end else if (port == PORT_DATA) begin
               d6    = {26'd0, din[5:0]};
               level = (d6 * 256) / 63;
               if (level > 255) level = 255;
               if (pal_ok) begin
                  sh = 16 - 8 * int'(wr_ph[cp]);
                  pal_mem[cp][wr_idx[cp]][sh +: 8]    = level[7:0];
                  pal_seen[cp][wr_idx[cp]][wr_ph[cp]] = 1'b1;
               end
               if (wr_ph[cp] == PHASE_BLUE) begin
                  wr_ph[cp]  = PHASE_RED;
                  wr_idx[cp] = wr_idx[cp] + 8'd1;
               end else begin
                  wr_ph[cp] = wr_ph[cp] + 2'd1;
               end
            end else begin
               rep.unsupported = 1'b1;
            end
         end
         ACT_PORT_READ: begin
            if (port == PORT_DATA) begin
               // without a palette the read returns zero and the pointers stay put
               if (pal_ok) begin
                  sh    = 16 - 8 * int'(rd_ph[cp]);
                  level = {24'd0, pal_mem[cp][rd_idx[cp]][sh +: 8]};
                  level = (level * 64) / 255;
                  if (level > 63) level = 63;
                  rep.read_data = level[7:0];
                  if (rd_ph[cp] == PHASE_BLUE) begin
                     rd_ph[cp]  = PHASE_RED;
                     rd_idx[cp] = rd_idx[cp] + 8'd1;
                  end else begin
                     rd_ph[cp] = rd_ph[cp] + 2'd1;
                  end
               end
            end else if (port == PORT_STAT) begin
               if (retr_pend[cp] || active) begin
                  retr_pend[cp] = 1'b0;
                  rep.read_data = STAT_RETRACE;
               end
            end else if (port == PORT_KBD) begin
               // the head stays on the last popped code, so an empty queue repeats it
               rep.read_data = key_mem[cp][key_head[cp]];
               if (key_cnt[cp] > 0) begin
                  if (key_cnt[cp] > 1) key_head[cp] = (key_head[cp] + 1) % KQ_DEPTH;
                  key_cnt[cp]--;
               end
            end else begin
               rep.unsupported = 1'b1;
            end
         end
         ACT_KEY_PUSH: begin
            if (key_cnt[cp] < KQ_DEPTH) begin
               key_mem[cp][(key_head[cp] + key_cnt[cp]) % KQ_DEPTH] = din;
               key_cnt[cp]++;
            end
         end
         default: begin
            retr_pend[cp] = 1'b1;
         end
      endcase
      rep.blink_on = blink_st[cp];
   endfunction

   task automatic send(input logic [1:0] act, input logic [15:0] port, input logic [7:0] din,
                       input logic active, input logic pal);
      port_reply_t dummy;
      // a palette channel that was never written holds no defined value
      if (act == ACT_PORT_READ && port == PORT_DATA && pal && !pal_seen[0][rd_idx[0]][rd_ph[0]])
         pal = 1'b0;
      dac_port_step(0, act, port, din, active, pal, dummy);
      pending.push_back({act, 6'd0, pal, active, din, port});
      n_queued++;
   endtask

   function automatic int idle_len(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic [15:0] pick_port();
      case ($urandom_range(0, 13))
         0:  return PORT_ATTR;
         1:  return PORT_RIDX;
         2:  return PORT_WIDX;
         3:  return PORT_DATA;
         4:  return PORT_STAT;
         5:  return PORT_KBD;
         6:  return PORT_DATA + 16'd1;
         7:  return PORT_ATTR - 16'd1;
         8:  return PORT_STAT + 16'd1;
         9:  return PORT_KBD + 16'd1;
         10: return 16'hFFFF;
         11: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic report_error(input string msg);
      n_errors++;
      if (n_errors <= 40) $display("%0t ns: %s", $time, msg);
   endtask

   // item driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if ($urandom_range(0, 63) == 0) req_calm = ~req_calm;
         if (req_hold > 0) begin
            req_tvalid <= 1'b0;
            req_hold--;
         end else if (pending.size() != 0) begin
            {req_tuser, req_tdata} <= pending.pop_front();
            req_tvalid <= 1'b1;
            req_hold = idle_len(req_calm);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if ($urandom_range(0, 63) == 0) rsp_calm = ~rsp_calm;
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
         rsp_hold = idle_len(rsp_calm);
      end
   end

   // monitor: predict on accept, check on response
   always @(posedge clock) begin : monitor
      port_reply_t rep;
      port_reply_t want;
      req_took <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            dac_port_step(1, req_tuser, req_tdata[15:0], req_tdata[23:16], req_tdata[24],
                          req_tdata[25], rep);
            replies_due.push_back(rep);
            n_accepted++;
            if (rep.unsupported) n_unsup++;
            if (req_tuser == ACT_PORT_READ && req_tdata[15:0] == PORT_DATA && req_tdata[25])
               n_pal_reads++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) begin
               report_error("response item with no request outstanding");
            end else begin
               want = replies_due.pop_front();
               n_checked++;
               if (rsp_tdata !== want.read_data)
                  report_error($sformatf("read_data got %h want %h", rsp_tdata, want.read_data));
               if (rsp_tuser[0] !== want.unsupported)
                  report_error($sformatf("unsupported got %b want %b", rsp_tuser[0],
                                         want.unsupported));
               if (rsp_tuser[1] !== want.blink_on)
                  report_error($sformatf("blink_on got %b want %b", rsp_tuser[1],
                                         want.blink_on));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d responses outstanding", replies_due.size());
         $display("** vga_dac_port_device_core: FAILED **");
         $finish;
      end
   end

   initial begin
      int n, idx, k;
      dac_state_clear(0);
      dac_state_clear(1);

      // directed part
      send(ACT_PORT_READ,  PORT_KBD,  8'h00, 1'b0, 1'b1);   // empty queue after reset
      send(ACT_PORT_WRITE, PORT_ATTR, 8'h08, 1'b1, 1'b0);
      send(ACT_PORT_WRITE, PORT_ATTR, 8'hF7, 1'b0, 1'b1);
      send(ACT_PORT_WRITE, PORT_WIDX, 8'hFF, 1'b0, 1'b1);
      send(ACT_PORT_WRITE, PORT_DATA, 8'h3F, 1'b0, 1'b1);
      send(ACT_PORT_WRITE, PORT_DATA, 8'h00, 1'b1, 1'b1);
      send(ACT_PORT_WRITE, PORT_DATA, 8'hFF, 1'b0, 1'b1);   // index wraps to zero
      send(ACT_PORT_WRITE, PORT_DATA, 8'h20, 1'b0, 1'b0);   // no palette, phase still steps
      send(ACT_PORT_WRITE, PORT_RIDX, 8'hFF, 1'b0, 1'b1);
      send(ACT_PORT_READ,  PORT_DATA, 8'h00, 1'b0, 1'b0);   // no palette, no step
      repeat (3) send(ACT_PORT_READ, PORT_DATA, 8'h00, 1'b0, 1'b1);
      send(ACT_PORT_READ,  PORT_STAT, 8'h00, 1'b0, 1'b1);
      send(ACT_RETRACE,    16'h1234,  8'h55, 1'b0, 1'b0);
      send(ACT_PORT_READ,  PORT_STAT, 8'h00, 1'b0, 1'b1);
      send(ACT_PORT_READ,  PORT_STAT, 8'h00, 1'b1, 1'b0);
      send(ACT_KEY_PUSH,   16'hFFFF,  8'h00, 1'b1, 1'b1);
      send(ACT_KEY_PUSH,   16'h0000,  8'hFF, 1'b0, 1'b0);
      repeat (3) send(ACT_PORT_READ, PORT_KBD, 8'h00, 1'b0, 1'b1);
      send(ACT_PORT_WRITE, PORT_STAT, 8'hFF, 1'b1, 1'b1);
      send(ACT_PORT_WRITE, PORT_KBD,  8'hAA, 1'b0, 1'b1);
      send(ACT_PORT_READ,  PORT_ATTR, 8'h00, 1'b0, 1'b1);
      send(ACT_PORT_READ,  PORT_RIDX, 8'h00, 1'b0, 1'b1);
      send(ACT_PORT_READ,  PORT_WIDX, 8'h00, 1'b1, 1'b1);
      send(ACT_PORT_READ,  16'hFFFF,  8'hFF, 1'b1, 1'b1);

      // random part, mostly well-formed palette and status sequences
      k = n_queued + N_RANDOM;
      while (n_queued < k) begin
         case ($urandom_range(0, 99)) inside
            [0:24]: begin
               n = $urandom_range(0, 9);
               idx = (n == 0) ? 255 : (n == 1) ? 0 : $urandom_range(0, 255);
               send(ACT_PORT_WRITE, PORT_WIDX, 8'(idx), 1'($urandom), 1'($urandom));
               repeat ($urandom_range(1, 7))
                  send(ACT_PORT_WRITE, PORT_DATA, 8'($urandom), 1'($urandom),
                       $urandom_range(0, 9) != 0);
            end
            [25:44]: begin
               idx = $urandom_range(0, 255);
               for (int t = 0; t < 8 && pal_seen[0][idx] != 3'b111; t++)
                  idx = $urandom_range(0, 255);
               send(ACT_PORT_WRITE, PORT_RIDX, 8'(idx), 1'($urandom), 1'($urandom));
               repeat ($urandom_range(1, 7))
                  send(ACT_PORT_READ, PORT_DATA, 8'($urandom), 1'($urandom),
                       $urandom_range(0, 9) != 0);
            end
            [45:54]: send(ACT_PORT_WRITE, PORT_ATTR, 8'($urandom), 1'($urandom),
                          1'($urandom));
            [55:64]: begin
               if ($urandom_range(0, 1))
                  send(ACT_RETRACE, 16'($urandom), 8'($urandom), 1'($urandom),
                       1'($urandom));
               send(ACT_PORT_READ, PORT_STAT, 8'($urandom), $urandom_range(0, 3) == 0,
                    1'($urandom));
            end
            [65:79]: begin
               repeat ($urandom_range(1, 4))
                  send($urandom_range(0, 1) ? ACT_KEY_PUSH : ACT_PORT_READ,
                       $urandom_range(0, 1) ? PORT_KBD : 16'($urandom), 8'($urandom),
                       1'($urandom), 1'($urandom));
            end
            default: send(2'($urandom), pick_port(), 8'($urandom), 1'($urandom),
                          1'($urandom));
         endcase
      end

      // fill the key queue past its depth, then pop a few codes
      while (key_cnt[0] < KQ_DEPTH)
         send(ACT_KEY_PUSH, 16'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      queue_filled = 1;
      repeat (3) send(ACT_KEY_PUSH, 16'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      repeat (8) begin
         send(ACT_PORT_READ, PORT_KBD, 8'($urandom), 1'($urandom), 1'($urandom));
         if ($urandom_range(0, 7) == 0)
            send(2'($urandom), pick_port(), 8'($urandom), 1'($urandom), 1'($urandom));
      end

      while (reset) @(negedge clock);
      while (n_accepted != n_queued || replies_due.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("%0d requests accepted, %0d responses checked", n_accepted, n_checked);
      $display("%0d palette data reads, %0d unsupported accesses, key queue filled: %0d",
               n_pal_reads, n_unsup, queue_filled);
      if (n_errors == 0) begin
         $display("** vga_dac_port_device_core: PASSED **");
      end else begin
         $display("** vga_dac_port_device_core: FAILED **");
      end
      $finish;
   end

endmodule
